@@ rtl/core/heightfield_quad_normals_assert.svh @@
`ifndef HEIGHTFIELD_QUAD_NORMALS_ASSERT_SVH
`define HEIGHTFIELD_QUAD_NORMALS_ASSERT_SVH

// Checked only out of reset.
`define HQN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HQN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/hqn_pkg.sv @@
package hqn_pkg;

  localparam int GRID_SIZE = 1024;
  localparam int COL_W     = 10;
  localparam int COL_MAX   = GRID_SIZE - 2;
  localparam int H_W       = 16;
  localparam int S_W       = 16;
  localparam int POS_W     = 26;
  localparam int NRM_W     = 16;
  localparam int ONE_Q14   = 16384;
  localparam int LANES     = 6;

  // Lane order: first triangle x y z, second triangle x y z.
  localparam int LN_N1X = 0;
  localparam int LN_N1Y = 1;
  localparam int LN_N1Z = 2;
  localparam int LN_N2X = 3;
  localparam int LN_N2Y = 4;
  localparam int LN_N2Z = 5;

  localparam int MAG_W  = 16;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int LEN_W  = SQ_W + 2;
  localparam int FRAC_W = 30;
  localparam int REM_W  = SQ_W + FRAC_W;
  localparam int ROOT_W = 16;
  localparam int PROD_W = LEN_W + ROOT_W;
  localparam int CMP_W  = 68;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [PROD_W-1:0] prod;
    logic [ROOT_W-1:0] root;
    logic [LEN_W-1:0]  len2;
    logic              neg;
  } lane_t;

  typedef struct packed {
    logic [POS_W-1:0]     x0;
    logic [POS_W-1:0]     x1;
    logic [POS_W-1:0]     z0;
    logic [POS_W-1:0]     z1;
    logic signed [H_W-1:0] h00;
    logic signed [H_W-1:0] h10;
    logic signed [H_W-1:0] h11;
    logic signed [H_W-1:0] h01;
    logic                 flat;
  } quad_t;

  // One digit of t = max { t : t*t*len2 <= mag*mag << 30 }, bit k.
  function automatic lane_t rsq_step(lane_t l, int unsigned k);
    logic [CMP_W-1:0] d;
    lane_t            o;
    o = l;
    d = ({{(CMP_W-PROD_W){1'b0}}, l.prod} << (k + 1))
      + ({{(CMP_W-LEN_W){1'b0}}, l.len2} << (2 * k));
    if ({{(CMP_W-REM_W){1'b0}}, l.rem} >= d) begin
      o.rem  = l.rem - d[REM_W-1:0];
      o.prod = l.prod + (PROD_W'(l.len2) << k);
      o.root = l.root | (ROOT_W'(1) << k);
    end
    return o;
  endfunction

endpackage

@@ rtl/core/hqn_norm_pipe.sv @@
module hqn_norm_pipe import hqn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_vld,
  input  lane_t in_lane [LANES],
  input  quad_t in_quad,
  output logic  out_vld,
  output lane_t out_lane [LANES],
  output quad_t out_quad
);

  lane_t             lane_r [ROOT_W][LANES];
  quad_t             quad_r [ROOT_W];
  logic [ROOT_W-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[ROOT_W-2:0], in_vld};
    end
  end

  // Stage g resolves root bit ROOT_W-1-g for all six lanes.
  for (genvar g = 0; g < ROOT_W; g++) begin : g_stg
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          quad_r[g] <= in_quad;
          for (int l = 0; l < LANES; l++) begin
            lane_r[g][l] <= rsq_step(in_lane[l], ROOT_W - 1);
          end
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          quad_r[g] <= quad_r[g-1];
          for (int l = 0; l < LANES; l++) begin
            lane_r[g][l] <= rsq_step(lane_r[g-1][l], ROOT_W - 1 - g);
          end
        end
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_quad = quad_r[ROOT_W-1];
  assign out_lane = lane_r[ROOT_W-1];

endmodule

@@ rtl/core/heightfield_quad_normals.sv @@
// Grid quad to two flat-shaded triangles. One quad is accepted on the in_ channel and
// six vertices leave on the out_ channel, one per cycle while out_tready is high, paced
// by the output vertex sequencer. From acceptance to the first vertex a quad passes
// three front stages (differences, squares, lengths), a 16-stage digit-by-digit
// reciprocal square root, all six normal components in parallel lanes, and the
// sequencer register. Quads beyond the grid edge are dropped without output.
module heightfield_quad_normals import hqn_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,   // grid_scale
  input  logic         in_tvalid,
  output logic         in_tready,
  // quad_col, quad_row, height_00, height_10, height_11, height_01, zero pad
  input  logic [87:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, zero pad
  output logic [119:0] out_tdata,
  output logic         out_tlast      // last_vertex
);

  `include "heightfield_quad_normals_assert.svh"

  localparam int NY_MSB = 99;

  typedef enum logic [2:0] {VTX_0, VTX_1, VTX_2, VTX_3, VTX_4, VTX_5} vtx_t;

  logic [S_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= S_W'(256);
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  logic [COL_W-1:0]      i_col, i_row;
  logic signed [H_W-1:0] i_h00, i_h10, i_h11, i_h01;
  assign i_col = in_tdata[9:0];
  assign i_row = in_tdata[19:10];
  assign i_h00 = in_tdata[35:20];
  assign i_h10 = in_tdata[51:36];
  assign i_h11 = in_tdata[67:52];
  assign i_h01 = in_tdata[83:68];

  logic adv, load_ok, pipe_vld;
  assign in_tready = adv;

  // Stage A: differences and magnitudes
  logic signed [H_W:0] dif [LANES];
  logic                a_vld_r;
  logic [MAG_W-1:0]    a_mag_r [LANES];
  logic                a_neg_r [LANES];
  logic [COL_W-1:0]    a_col_r, a_row_r;
  logic [S_W-1:0]      a_s_r;
  logic signed [H_W-1:0] a_h00_r, a_h10_r, a_h11_r, a_h01_r;

  always_comb begin
    dif[LN_N1X] = {i_h00[H_W-1], i_h00} - {i_h10[H_W-1], i_h10};
    dif[LN_N1Y] = {1'b0, scale_r};
    dif[LN_N1Z] = {i_h10[H_W-1], i_h10} - {i_h11[H_W-1], i_h11};
    dif[LN_N2X] = {i_h01[H_W-1], i_h01} - {i_h11[H_W-1], i_h11};
    dif[LN_N2Y] = {1'b0, scale_r};
    dif[LN_N2Z] = {i_h00[H_W-1], i_h00} - {i_h01[H_W-1], i_h01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_tvalid && ({1'b0, i_col} <= (COL_W+1)'(COL_MAX))
                           && ({1'b0, i_row} <= (COL_W+1)'(COL_MAX));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        a_neg_r[l] <= dif[l][H_W];
        a_mag_r[l] <= dif[l][H_W] ? MAG_W'(-dif[l]) : dif[l][MAG_W-1:0];
      end
      a_col_r <= i_col;
      a_row_r <= i_row;
      a_s_r   <= scale_r;
      a_h00_r <= i_h00;
      a_h10_r <= i_h10;
      a_h11_r <= i_h11;
      a_h01_r <= i_h01;
    end
  end

  // Stage B: squares and base positions
  logic               b_vld_r;
  logic [SQ_W-1:0]    b_sq_r [LANES];
  logic               b_neg_r [LANES];
  logic [POS_W-1:0]   b_x0_r, b_z0_r;
  logic [S_W-1:0]     b_s_r;
  logic signed [H_W-1:0] b_h00_r, b_h10_r, b_h11_r, b_h01_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        b_sq_r[l]  <= SQ_W'(a_mag_r[l]) * SQ_W'(a_mag_r[l]);
        b_neg_r[l] <= a_neg_r[l];
      end
      b_x0_r  <= POS_W'(a_col_r) * POS_W'(a_s_r);
      b_z0_r  <= POS_W'(a_row_r) * POS_W'(a_s_r);
      b_s_r   <= a_s_r;
      b_h00_r <= a_h00_r;
      b_h10_r <= a_h10_r;
      b_h11_r <= a_h11_r;
      b_h01_r <= a_h01_r;
    end
  end

  // Stage C: squared lengths, far corners, lane set-up
  logic  c_vld_r;
  lane_t c_lane_r [LANES];
  quad_t c_quad_r;
  logic [LEN_W-1:0] len1, len2;

  assign len1 = LEN_W'(b_sq_r[LN_N1X]) + LEN_W'(b_sq_r[LN_N1Y]) + LEN_W'(b_sq_r[LN_N1Z]);
  assign len2 = LEN_W'(b_sq_r[LN_N2X]) + LEN_W'(b_sq_r[LN_N2Y]) + LEN_W'(b_sq_r[LN_N2Z]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        c_lane_r[l].rem  <= {b_sq_r[l], {FRAC_W{1'b0}}};
        c_lane_r[l].prod <= '0;
        c_lane_r[l].root <= '0;
        c_lane_r[l].len2 <= (l < LN_N2X) ? len1 : len2;
        c_lane_r[l].neg  <= b_neg_r[l];
      end
      c_quad_r.x0   <= b_x0_r;
      c_quad_r.z0   <= b_z0_r;
      c_quad_r.x1   <= b_x0_r + POS_W'(b_s_r);
      c_quad_r.z1   <= b_z0_r + POS_W'(b_s_r);
      c_quad_r.h00  <= b_h00_r;
      c_quad_r.h10  <= b_h10_r;
      c_quad_r.h11  <= b_h11_r;
      c_quad_r.h01  <= b_h01_r;
      c_quad_r.flat <= (b_s_r == '0);
    end
  end

  lane_t p_lane [LANES];
  quad_t p_quad;

  hqn_norm_pipe u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (c_vld_r),
    .in_lane  (c_lane_r),
    .in_quad  (c_quad_r),
    .out_vld  (pipe_vld),
    .out_lane (p_lane),
    .out_quad (p_quad)
  );

  // Round: rnd = (t + 1) / 2, then apply the sign; a flat quad (zero scale) gets (0, 1, 0).
  logic signed [NRM_W-1:0] fin [LANES];
  logic [ROOT_W:0]         rnd [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rnd[l] = ({1'b0, p_lane[l].root} + (ROOT_W+1)'(1)) >> 1;
      fin[l] = p_lane[l].neg ? NRM_W'(-rnd[l]) : rnd[l][NRM_W-1:0];
      if (p_quad.flat) begin
        fin[l] = (l == LN_N1Y || l == LN_N2Y) ? NRM_W'(ONE_Q14) : '0;
      end
    end
  end

  // Vertex sequencer
  logic                    s_busy_r;
  vtx_t                    s_cnt_r;
  quad_t                   s_quad_r;
  logic signed [NRM_W-1:0] s_norm_r [LANES];

  assign load_ok = !s_busy_r || (out_tready && s_cnt_r == VTX_5);
  assign adv     = !pipe_vld || load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_busy_r <= 1'b0;
      s_cnt_r  <= VTX_0;
    end else if (pipe_vld && load_ok) begin
      s_busy_r <= 1'b1;
      s_cnt_r  <= VTX_0;
    end else if (s_busy_r && out_tready) begin
      if (s_cnt_r == VTX_5) begin
        s_busy_r <= 1'b0;
      end else begin
        s_cnt_r <= vtx_t'(s_cnt_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_vld && load_ok) begin
      s_quad_r <= p_quad;
      s_norm_r <= fin;
    end
  end

  logic [POS_W-1:0]        o_x, o_z;
  logic signed [H_W-1:0]   o_y;
  logic signed [NRM_W-1:0] o_nx, o_ny, o_nz;
  logic                    tri2;

  always_comb begin
    o_x  = s_quad_r.x0;
    o_y  = s_quad_r.h00;
    o_z  = s_quad_r.z0;
    tri2 = 1'b0;
    case (s_cnt_r)
      VTX_0: begin
      end
      VTX_1: begin
        o_x = s_quad_r.x1;
        o_y = s_quad_r.h10;
      end
      VTX_2: begin
        o_x = s_quad_r.x1;
        o_y = s_quad_r.h11;
        o_z = s_quad_r.z1;
      end
      VTX_3: begin
        o_x  = s_quad_r.x1;
        o_y  = s_quad_r.h11;
        o_z  = s_quad_r.z1;
        tri2 = 1'b1;
      end
      VTX_4: begin
        o_y  = s_quad_r.h01;
        o_z  = s_quad_r.z1;
        tri2 = 1'b1;
      end
      VTX_5: begin
        tri2 = 1'b1;
      end
      default: begin
      end
    endcase
    o_nx = tri2 ? s_norm_r[LN_N2X] : s_norm_r[LN_N1X];
    o_ny = tri2 ? s_norm_r[LN_N2Y] : s_norm_r[LN_N1Y];
    o_nz = tri2 ? s_norm_r[LN_N2Z] : s_norm_r[LN_N1Z];
  end

  assign out_tvalid = s_busy_r;
  assign out_tlast  = (s_cnt_r == VTX_5);
  assign out_tdata  = {4'b0, o_nz, o_ny, o_nx, o_z, o_y, o_x};

  `HQN_ASSERT(a_quad_whole, (out_tvalid && out_tready && !out_tlast) |=> out_tvalid, "quad cut short")
  `HQN_ASSERT(a_busy_end, $fell(s_busy_r) |-> $past(out_tvalid && out_tready && out_tlast), "vertex lost")
  `HQN_ASSERT(a_ny_up, out_tvalid |-> !out_tdata[NY_MSB], "normal y below zero")
  `HQN_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule
